// ----- rtl/sobth_pkg.sv -----
// ----------------------------------------------------------------------------
// sobth_pkg
// Types and constants shared by the sobel edge threshold block.
// ----------------------------------------------------------------------------
package sobth_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD    = 2'd2;

  localparam int CFG_BITS = 11;

  localparam logic [7:0] PIXEL_EDGE  = 8'd0;
  localparam logic [7:0] PIXEL_WHITE = 8'd255;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_ABITS = 3;

  typedef struct packed {
    logic       edge_found;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } result_t;

endpackage

// ----- rtl/sobel_edge_threshold.sv -----
// result: pixel (r+1, c+1) completes the window of (r, c); its result passes
//   stage 1, the window, stage 3 and the result queue before out_valid rises
// throughput: one pixel per clock; stall rises only in reset or when the
//   8-entry result queue plus the pixels in the 3-stage pipe would fill it
// reset: counters and window cleared, size 512x512, threshold 38;
//   the line RAMs are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// Streaming 3x3 sobel edge detector with a magnitude threshold.
// ----------------------------------------------------------------------------
module sobel_edge_threshold
  import sobth_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                valid,
  output logic                stall,
  input  logic [7:0]          pixel,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_pixel,
  output logic [9:0]          out_row,
  output logic [9:0]          out_col,
  output logic                frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int RST_W_LAST = ((512 > MAX_WIDTH) ? MAX_WIDTH : 512) - 1;
  localparam int RST_H_LAST = ((512 > MAX_HEIGHT) ? MAX_HEIGHT : 512) - 1;
  localparam int FW = FIFO_ABITS + 1;

  // configuration, kept as last column / last row and squared threshold
  logic [CW-1:0] width_last;
  logic [RW-1:0] height_last;
  logic [21:0]   thr_sq;
  logic [CW-1:0] cfg_w_last;
  logic [RW-1:0] cfg_h_last;

  // position of the next pixel
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic          accept;

  // stage 1: line RAM data returns
  logic          v1;
  logic [7:0]    px1;
  logic [CW-1:0] col1;
  logic          row0_1;
  logic          row1_1;
  logic          col0_1;
  logic          emit1;
  logic          last1;
  logic [9:0]    out_row1;
  logic [9:0]    out_col1;
  logic [7:0]    rd_above;
  logic [7:0]    rd_two;
  logic [7:0]    col_in [3];

  logic [7:0]    win [3][3];

  // stage 2: gradients
  logic          v2;
  logic [9:0]    row2;
  logic [9:0]    col2;
  logic          last2;
  logic [9:0]    sum_top;
  logic [9:0]    sum_bot;
  logic [9:0]    sum_lft;
  logic [9:0]    sum_rgt;
  logic [9:0]    mag_v;
  logic [9:0]    mag_h;

  // stage 3: squared magnitude against threshold
  logic          v3;
  logic [9:0]    m1;
  logic [9:0]    m2;
  logic [9:0]    row3;
  logic [9:0]    col3;
  logic          last3;
  logic [20:0]   mag_sq;
  result_t       res3;

  // result queue
  result_t               res_queue [FIFO_DEPTH];
  logic [FIFO_ABITS-1:0] wr_ptr;
  logic [FIFO_ABITS-1:0] rd_ptr;
  logic [FW-1:0]         fifo_count;
  logic [FW-1:0]         fill;
  logic                  push;
  logic                  pop;
  result_t               head;

  always_comb begin
    if (cfg_data < CFG_BITS'(2)) begin
      cfg_w_last = CW'(1);
    end else if (int'(cfg_data) > MAX_WIDTH) begin
      cfg_w_last = CW'(MAX_WIDTH - 1);
    end else begin
      cfg_w_last = CW'(cfg_data - CFG_BITS'(1));
    end
  end

  always_comb begin
    if (cfg_data < CFG_BITS'(2)) begin
      cfg_h_last = RW'(1);
    end else if (int'(cfg_data) > MAX_HEIGHT) begin
      cfg_h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      cfg_h_last = RW'(cfg_data - CFG_BITS'(1));
    end
  end

  // the queue reserves a slot for every pixel still in the pipe
  assign fill   = fifo_count + FW'(v1) + FW'(v2) + FW'(v3);
  assign stall  = rst || (fill >= FW'(FIFO_DEPTH));
  assign accept = valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= CW'(RST_W_LAST);
      height_last <= RW'(RST_H_LAST);
      thr_sq      <= 22'(38 * 38);
      col_count   <= '0;
      row_count   <= '0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  width_last <= cfg_w_last;
          REG_IMAGE_HEIGHT: height_last <= cfg_h_last;
          REG_THRESHOLD:    thr_sq <= 22'(cfg_data) * 22'(cfg_data);
          default: ;
        endcase
      end
      // a size write restarts the frame
      if (cfg_wen && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
        col_count <= '0;
        row_count <= '0;
      end else if (accept) begin
        if (col_count == width_last) begin
          col_count <= '0;
          if (row_count == height_last) begin
            row_count <= '0;
          end else begin
            row_count <= row_count + RW'(1);
          end
        end else begin
          col_count <= col_count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1 && emit1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px1      <= pixel;
      col1     <= col_count;
      row0_1   <= (row_count == '0);
      row1_1   <= (row_count == RW'(1));
      col0_1   <= (col_count == '0);
      emit1    <= (row_count != '0) && (col_count != '0);
      last1    <= (row_count == height_last) && (col_count == width_last);
      out_row1 <= 10'(row_count - RW'(1));
      out_col1 <= 10'(col_count - CW'(1));
    end
    row2  <= out_row1;
    col2  <= out_col1;
    last2 <= last1;
    m1    <= mag_v;
    m2    <= mag_h;
    row3  <= row2;
    col3  <= col2;
    last3 <= last2;
  end

  // adjacent pixels never share a column, so each write-back lands
  // before the same entry is read again
  sobth_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_line_above (
    .clk     (clk),
    .wr_en   (v1),
    .wr_addr (col1),
    .wr_data (px1),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (rd_above)
  );

  sobth_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_line_two_above (
    .clk     (clk),
    .wr_en   (v1),
    .wr_addr (col1),
    .wr_data (rd_above),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (rd_two)
  );

  // top rows replicate upward
  always_comb begin
    col_in[2] = px1;
    if (row0_1) begin
      col_in[1] = px1;
      col_in[0] = px1;
    end else begin
      col_in[1] = rd_above;
      col_in[0] = row1_1 ? rd_above : rd_two;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (v1) begin
      for (int k = 0; k < 3; k++) begin
        if (col0_1) begin
          // left column replicates outward
          win[k][0] <= col_in[k];
          win[k][1] <= col_in[k];
          win[k][2] <= col_in[k];
        end else begin
          win[k][0] <= win[k][1];
          win[k][1] <= win[k][2];
          win[k][2] <= col_in[k];
        end
      end
    end
  end

  always_comb begin
    sum_top = 10'(win[0][0]) + {1'b0, win[0][1], 1'b0} + 10'(win[0][2]);
    sum_bot = 10'(win[2][0]) + {1'b0, win[2][1], 1'b0} + 10'(win[2][2]);
    sum_lft = 10'(win[0][0]) + {1'b0, win[1][0], 1'b0} + 10'(win[2][0]);
    sum_rgt = 10'(win[0][2]) + {1'b0, win[1][2], 1'b0} + 10'(win[2][2]);
    mag_v = (sum_bot >= sum_top) ? (sum_bot - sum_top) : (sum_top - sum_bot);
    mag_h = (sum_rgt >= sum_lft) ? (sum_rgt - sum_lft) : (sum_lft - sum_rgt);
  end

  always_comb begin
    mag_sq = 21'(m1) * 21'(m1) + 21'(m2) * 21'(m2);
    res3.edge_found = ({1'b0, mag_sq} >= thr_sq);
    res3.row = row3;
    res3.col = col3;
    res3.last = last3;
  end

  assign push = v3;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_ABITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_ABITS'(1);
      end
      if (push && !pop) begin
        fifo_count <= fifo_count + FW'(1);
      end else if (pop && !push) begin
        fifo_count <= fifo_count - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_queue[wr_ptr] <= res3;
    end
  end

  assign head       = res_queue[rd_ptr];
  assign out_valid  = (fifo_count != '0);
  assign out_pixel  = head.edge_found ? PIXEL_EDGE : PIXEL_WHITE;
  assign out_row    = head.row;
  assign out_col    = head.col;
  assign frame_last = head.last;

endmodule

// ----- rtl/sobth_ram.sv -----
// ----------------------------------------------------------------------------
// sobth_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sobth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
